@@ rtl/fnr_pkg.sv @@
`default_nettype none
package fnr_pkg;

  // default word width of numerator and denominator
  localparam int WORD_BITS_DEF = 32;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_OUT
  } fnr_state_t;

endpackage
`default_nettype wire

@@ rtl/fraction_normalize_reduce.sv @@
`default_nettype none
// Reduces a signed fraction num/den to lowest terms. The result carries the sign in the
// numerator and a positive denominator; 0/d becomes 0/1. A zero denominator, or either input
// equal to the most negative word, returns zero_den_error = 1 with both outputs zero. One
// request is worked on at a time, and in_tready is high only while the block is idle. All
// arithmetic runs through one shared (WORD_BITS+1)-bit subtractor under a small sequencer:
// a binary GCD (one shift, subtract or swap per cycle), then two restoring divisions by
// the GCD, and finally the result is loaded into the output register. A result that is
// not taken holds the sequencer in its last state until the output register frees up.
// The output register lets the next request enter while a result still waits to be taken.
module fraction_normalize_reduce
  import fnr_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int IN_TDATA_W = ((2 * WORD_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((2 * WORD_BITS - 1 + 7) / 8) * 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // in_tdata, from bit 0 up: num_in (WORD_BITS, signed), den_in (WORD_BITS, signed), zero pad
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // out_tdata, from bit 0 up: num_out (WORD_BITS, signed), den_out (WORD_BITS-1), zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: zero_den_error (1)
  output logic                   out_tuser
);

  localparam int MW = WORD_BITS - 1;
  localparam int KW = $clog2(WORD_BITS);

  fnr_state_t state_r, state_nxt;

  logic [MW-1:0]        a_r, a_nxt;
  logic [MW-1:0]        b_r, b_nxt;
  logic [MW-1:0]        an_r, an_nxt;
  logic [MW-1:0]        ad_r, ad_nxt;
  logic [MW-1:0]        g_r, g_nxt;
  logic [MW-1:0]        rem_r, rem_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [KW-1:0]        cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 err_r, err_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_num_r, out_num_nxt;
  logic [MW-1:0]        out_den_r, out_den_nxt;
  logic                 out_err_r, out_err_nxt;

  // input decode
  logic [WORD_BITS-1:0] n_w, d_w;
  logic [MW-1:0]        n_neg, d_neg;
  logic                 in_bad;
  assign n_w   = in_tdata[WORD_BITS-1:0];
  assign d_w   = in_tdata[2*WORD_BITS-1:WORD_BITS];
  assign n_neg = ~n_w[MW-1:0] + 1'b1;
  assign d_neg = ~d_w[MW-1:0] + 1'b1;
  assign in_bad = (d_w == '0) || (n_w == {1'b1, {MW{1'b0}}}) || (d_w == {1'b1, {MW{1'b0}}});

  // shared subtractor: GCD compare/subtract, or one division step
  logic [MW:0]   sub_x, sub_y;
  logic [MW+1:0] sub_d;
  logic          borrow;
  always_comb begin
    if (state_r == S_GCD) begin
      sub_x = {1'b0, a_r};
      sub_y = {1'b0, b_r};
    end else begin
      sub_x = {rem_r, a_r[MW-1]};
      sub_y = {1'b0, g_r};
    end
  end
  assign sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow = sub_d[MW+1];

  // signed result numerator
  logic [WORD_BITS-1:0] qn_ext;
  assign qn_ext = {1'b0, b_r};

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    g_nxt         = g_r;
    rem_nxt       = rem_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_num_nxt   = out_num_r;
    out_den_nxt   = out_den_r;
    out_err_nxt   = out_err_r;
    in_tready     = (state_r == S_IDLE);

    unique case (state_r) inside
      S_IDLE: begin
        if (in_tvalid) begin
          an_nxt  = n_w[WORD_BITS-1] ? n_neg : n_w[MW-1:0];
          ad_nxt  = d_w[WORD_BITS-1] ? d_neg : d_w[MW-1:0];
          a_nxt   = an_nxt;
          b_nxt   = ad_nxt;
          k_nxt   = '0;
          neg_nxt = n_w[WORD_BITS-1] ^ d_w[WORD_BITS-1];
          err_nxt = in_bad;
          state_nxt = in_bad ? S_OUT : S_GCD;
        end
      end

      // binary GCD; b stays nonzero, finish when a reaches zero
      S_GCD: begin
        if (a_r == '0) begin
          g_nxt     = b_r << k_r;
          a_nxt     = an_r;
          rem_nxt   = '0;
          cnt_nxt   = KW'(MW - 1);
          state_nxt = S_DIVN;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (borrow) begin
          // both odd, a < b: swap so the subtract goes the right way
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          // both odd, a >= b: difference is even
          a_nxt = sub_d[MW:1];
        end
      end

      // restoring division steps, quotient shifts into a
      S_DIVN, S_DIVD: begin
        a_nxt   = {a_r[MW-2:0], ~borrow};
        rem_nxt = borrow ? sub_x[MW-1:0] : sub_d[MW-1:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (state_r == S_DIVN) begin
            b_nxt     = a_nxt;
            a_nxt     = ad_r;
            rem_nxt   = '0;
            cnt_nxt   = KW'(MW - 1);
            state_nxt = S_DIVD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          out_num_nxt   = err_r ? '0 : (neg_r ? (~qn_ext + 1'b1) : qn_ext);
          out_den_nxt   = err_r ? '0 : a_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    an_r      <= an_nxt;
    ad_r      <= ad_nxt;
    g_r       <= g_nxt;
    rem_r     <= rem_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    err_r     <= err_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_den_r, out_num_r});
  assign out_tuser  = out_err_r;

endmodule
`default_nettype wire

@@ rtl/fnr_checker.sv @@
`default_nettype none
module fnr_checker
  import fnr_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int OUT_TDATA_W = ((2 * WORD_BITS - 1 + 7) / 8) * 8
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_tvalid,
  input wire                   in_tready,
  input wire                   out_tvalid,
  input wire                   out_tready,
  input wire [OUT_TDATA_W-1:0] out_tdata,
  input wire                   out_tuser
);

  logic [WORD_BITS-1:0] num_f;
  logic [WORD_BITS-2:0] den_f;
  assign num_f = out_tdata[WORD_BITS-1:0];
  assign den_f = out_tdata[2*WORD_BITS-2:WORD_BITS];

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new request taken while busy");

  // rejected input gives zero outputs
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (num_f == '0) && (den_f == '0))
    else $error("error result not zero");

  // good result has a positive denominator
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> den_f != '0)
    else $error("zero denominator on good result");

  // zero reduces to 0/1
  a_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && (num_f == '0) |-> den_f == (WORD_BITS-1)'(1))
    else $error("zero numerator not over one");

endmodule

bind fraction_normalize_reduce fnr_checker #(.WORD_BITS(WORD_BITS)) u_fnr_checker (.*);
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import fnr_pkg::*;

  localparam int W = WORD_BITS_DEF;
  localparam int IN_W = ((2 * W + 7) / 8) * 8;
  localparam int OUT_W = ((2 * W - 1 + 7) / 8) * 8;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam int RANDOM_REQUESTS = 1450;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 600;

  // one reduced fraction as the block reports it
  typedef struct packed {
    logic [W-1:0] num;
    logic [W-2:0] den;
    logic         err;
  } fraction_t;

  // directed request; the result is typed in where it is obvious
  typedef struct {
    logic [W-1:0] num_in;
    logic [W-1:0] den_in;
    bit           typed;
    logic [W-1:0] num_out;
    logic [W-2:0] den_out;
    logic         err;
  } directed_row_t;

  localparam int DIRECTED_COUNT = 23;
  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{32'd6, 32'd4, 1'b1, 32'd3, 31'd2, 1'b0},
    '{32'd6, -32'd4, 1'b1, -32'd3, 31'd2, 1'b0},
    '{-32'd6, 32'd4, 1'b1, -32'd3, 31'd2, 1'b0},
    '{-32'd6, -32'd4, 1'b1, 32'd3, 31'd2, 1'b0},
    '{32'd1, 32'd1, 1'b1, 32'd1, 31'd1, 1'b0},
    // zero numerator comes back as 0/1
    '{32'd0, 32'd5, 1'b1, 32'd0, 31'd1, 1'b0},
    '{32'd0, -32'd7, 1'b1, 32'd0, 31'd1, 1'b0},
    // zero denominator
    '{32'd5, 32'd0, 1'b1, 32'd0, 31'd0, 1'b1},
    '{32'd0, 32'd0, 1'b1, 32'd0, 31'd0, 1'b1},
    '{MOST_POS, 32'd0, 1'b1, 32'd0, 31'd0, 1'b1},
    // most negative word on either side
    '{MOST_NEG, 32'd3, 1'b1, 32'd0, 31'd0, 1'b1},
    '{32'd3, MOST_NEG, 1'b1, 32'd0, 31'd0, 1'b1},
    '{MOST_NEG, MOST_NEG, 1'b1, 32'd0, 31'd0, 1'b1},
    '{MOST_NEG, 32'd0, 1'b1, 32'd0, 31'd0, 1'b1},
    // extremes of the legal range
    '{MOST_POS, MOST_POS, 1'b1, 32'd1, 31'd1, 1'b0},
    '{MOST_POS, 32'd1, 1'b1, MOST_POS, 31'd1, 1'b0},
    '{-MOST_POS, 32'd1, 1'b1, -MOST_POS, 31'd1, 1'b0},
    '{32'd1, -MOST_POS, 1'b1, -32'd1, MOST_POS[W-2:0], 1'b0},
    '{-MOST_POS, -MOST_POS, 1'b1, 32'd1, 31'd1, 1'b0},
    '{-32'd1, -32'd1, 1'b1, 32'd1, 31'd1, 1'b0},
    '{32'd12345678, 32'd87654321, 1'b0, 32'd0, 31'd0, 1'b0},
    '{32'h7fff_fffe, 32'h4000_0000, 1'b0, 32'd0, 31'd0, 1'b0},
    '{32'haaaa_aaaa, 32'h5555_5555, 1'b0, 32'd0, 31'd0, 1'b0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  wire              in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  wire              out_tvalid;
  logic             out_tready = 1'b0;
  wire  [OUT_W-1:0] out_tdata;
  wire              out_tuser;

  fraction_t pending_fractions [$];
  int        mismatches = 0;
  int        fractions_seen = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        holding = 1'b0;
  bit        steady = 1'b0;

  fraction_normalize_reduce DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // sign to the numerator, then divide both by the gcd
  function automatic fraction_t reduce_fraction(logic [W-1:0] n, logic [W-1:0] d);
    fraction_t    r;
    logic [W-1:0] an, ad, a, b, t, qn, qd;
    r = '0;
    if (d == '0 || n == MOST_NEG || d == MOST_NEG) begin
      r.err = 1'b1;
      return r;
    end
    an = n[W-1] ? -n : n;
    ad = d[W-1] ? -d : d;
    a = an;
    b = ad;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    qn = an / a;
    qd = ad / a;
    if (n[W-1] != d[W-1] && qn != '0)
      qn = -qn;
    r.num = qn;
    r.den = qd[W-2:0];
    return r;
  endfunction

  // offer one request, with random gaps before it unless steady is set
  task automatic send_fraction(logic [W-1:0] n, logic [W-1:0] d, fraction_t expected);
    while (!steady && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {d, n};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_fractions.push_back(expected);
  endtask

  // random operands, biased toward the interesting corners
  task automatic send_random_fraction();
    logic [W-1:0] n, d;
    int unsigned  g, pick;
    pick = $urandom_range(99);
    n = $urandom;
    d = $urandom;
    if (pick < 5) begin
      d = '0;
    end else if (pick < 8) begin
      if ($urandom_range(1)) n = MOST_NEG;
      else d = MOST_NEG;
    end else if (pick < 13) begin
      n = '0;
      if (d == '0) d = 32'd1;
    end else if (pick < 43) begin
      // operands sharing a factor
      g = $urandom_range(1, 65535);
      n = $urandom_range(0, MOST_POS / g) * g;
      d = $urandom_range(1, MOST_POS / g) * g;
      if ($urandom_range(1)) n = -n;
      if ($urandom_range(1)) d = -d;
    end else if (pick < 60) begin
      n = $urandom_range(0, 200);
      d = $urandom_range(1, 200);
      if ($urandom_range(1)) n = -n;
      if ($urandom_range(1)) d = -d;
    end
    send_fraction(n, d, reduce_fraction(n, d));
  endtask

  // stimulus: reset, directed table, random part, drain
  initial begin
    fraction_t expected;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (directed_rows[i].typed)
        expected = '{directed_rows[i].num_out, directed_rows[i].den_out, directed_rows[i].err};
      else
        expected = reduce_fraction(directed_rows[i].num_in, directed_rows[i].den_in);
      send_fraction(directed_rows[i].num_in, directed_rows[i].den_in, expected);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i >= 600 && i < 850);
      send_random_fraction();
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("fraction_normalize_reduce test passed");
    else
      $display("fraction_normalize_reduce test failed");
    $finish;
  end

  // one long hold-off fills the block and backs up the input
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && fractions_seen >= 120) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    holding <= (hold_left > 0);
  end

  // result side: check accepted results, then pick the next tready
  always @(posedge clk) begin
    fraction_t expected;
    fraction_t actual;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fraction_normalize_reduce test failed");
      $finish;
    end else begin
      if (rst_n && out_tvalid && out_tready) begin
        actual = '{out_tdata[W-1:0], out_tdata[2*W-2:W], out_tuser};
        fractions_seen++;
        if (pending_fractions.size() == 0) begin
          $error("unexpected result: num_out %0d den_out %0d zero_den_error %0b",
                 $signed(actual.num), actual.den, actual.err);
          mismatches++;
        end else begin
          expected = pending_fractions.pop_front();
          if (actual.num !== expected.num) begin
            $error("num_out: expected %0d, got %0d", $signed(expected.num), $signed(actual.num));
            mismatches++;
          end
          if (actual.den !== expected.den) begin
            $error("den_out: expected %0d, got %0d", expected.den, actual.den);
            mismatches++;
          end
          if (actual.err !== expected.err) begin
            $error("zero_den_error: expected %0b, got %0b", expected.err, actual.err);
            mismatches++;
          end
        end
      end

      out_tready <= !holding && (steady || ($urandom_range(99) >= 32));
    end
  end

endmodule
